/* src/npss_pkg.sv */
package npss_pkg;

   // Fixed field widths
   localparam int COORD_BITS  = 24;
   localparam int DIFF_W      = COORD_BITS + 1;
   localparam int SQ_W        = 2 * DIFF_W;
   localparam int DIST_W      = 52;
   localparam int TAG_W       = 16;
   localparam int INDEX_OUT_W = 10;

   // Cycles from the last read issue until the best-so-far registers settle
   localparam int DRAIN_CYCLES = 4;
   localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_QUERY = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   // Candidate leaving the distance pipe
   typedef struct packed {
      logic              valid;
      point_type         point;
      logic [DIST_W-1:0] gap;
   } cand_type;

   function automatic logic [DIFF_W-1:0] abs_diff(coord_type a, coord_type b);
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'(a) - DIFF_W'(b);
      return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

endpackage

/* src/npss_dist_unit.sv */
module npss_dist_unit #(
   parameter int IDX_W = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [IDX_W-1:0]     in_idx,
   input  npss_pkg::point_type  in_point,
   input  npss_pkg::point_type  query,
   output npss_pkg::cand_type   cand,
   output logic [IDX_W-1:0]     cand_idx
);

   // stage 1: absolute differences
   logic                         s1_valid_ff;
   logic [IDX_W-1:0]             s1_idx_ff;
   npss_pkg::point_type          s1_point_ff;
   logic [npss_pkg::DIFF_W-1:0]  mag_x_ff, mag_y_ff, mag_z_ff;

   // stage 2: squares
   logic                         s2_valid_ff;
   logic [IDX_W-1:0]             s2_idx_ff;
   npss_pkg::point_type          s2_point_ff;
   logic [npss_pkg::SQ_W-1:0]    sq_x_ff, sq_y_ff, sq_z_ff;

   // stage 3: sum
   logic                         s3_valid_ff;
   logic [IDX_W-1:0]             s3_idx_ff;
   npss_pkg::point_type          s3_point_ff;
   logic [npss_pkg::DIST_W-1:0]  sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff   <= in_idx;
      s1_point_ff <= in_point;
      mag_x_ff    <= npss_pkg::abs_diff(in_point.x, query.x);
      mag_y_ff    <= npss_pkg::abs_diff(in_point.y, query.y);
      mag_z_ff    <= npss_pkg::abs_diff(in_point.z, query.z);

      s2_idx_ff   <= s1_idx_ff;
      s2_point_ff <= s1_point_ff;
      sq_x_ff     <= mag_x_ff * mag_x_ff;
      sq_y_ff     <= mag_y_ff * mag_y_ff;
      sq_z_ff     <= mag_z_ff * mag_z_ff;

      s3_idx_ff   <= s2_idx_ff;
      s3_point_ff <= s2_point_ff;
      sum_ff      <= npss_pkg::DIST_W'(sq_x_ff) + npss_pkg::DIST_W'(sq_y_ff)
                     + npss_pkg::DIST_W'(sq_z_ff);
   end

   assign cand.valid = s3_valid_ff;
   assign cand.point = s3_point_ff;
   assign cand.gap   = sum_ff;
   assign cand_idx   = s3_idx_ff;

endmodule

/* src/npss_best_track.sv */
module npss_best_track #(
   parameter int IDX_W = 10
) (
   input  logic                         clock,
   input  npss_pkg::cand_type           cand,
   input  logic [IDX_W-1:0]             cand_idx,
   output logic [IDX_W-1:0]             best_idx,
   output npss_pkg::point_type          best_point,
   output logic [npss_pkg::DIST_W-1:0]  best_dist
);

   logic [IDX_W-1:0]             best_idx_ff;
   npss_pkg::point_type          best_point_ff;
   logic [npss_pkg::DIST_W-1:0]  best_dist_ff;
   logic                         take;

   // index 0 opens a scan; only a strictly smaller distance replaces the best
   assign take = cand.valid && ((cand_idx == '0) || (cand.gap < best_dist_ff));

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff   <= cand_idx;
         best_point_ff <= cand.point;
         best_dist_ff  <= cand.gap;
      end
   end

   assign best_idx   = best_idx_ff;
   assign best_point = best_point_ff;
   assign best_dist  = best_dist_ff;

endmodule

/* src/nearest_point_search_3d_unit.sv */
// Brute-force nearest point search over a stored 3D point cloud.
// Input channel (req_*): kind selects load, query or clear; coordinates are
//   signed Q16.8. A transfer happens when req_valid is high and req_stall low.
// Result channel (rsp_*): one result per query, and one per load dropped on a
//   full store; other loads, clears and unknown kinds give none.
// Loads into a store that is not full, clears and ignored kinds leave the
//   block idle, so req_stall stays low after them.
// A query scans the store in index order, one stored point per cycle out of
//   the point memory into a 4-stage distance/compare pipe. It holds req_stall
//   through the scan, drain and result states (only the result state when the
//   store is empty), and then for as long as an earlier result stays stalled.
// A full-store load likewise stalls in the result state until the output is free.
// Results sit in an output register: while rsp_stall is high the result
//   holds, and further loads and clears are still taken.
// Reset (synchronous, active high) empties the store and drops any pending
//   result; point memory contents are not cleared, since only entries below
//   the point count are ever read.
module nearest_point_search_3d_unit #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                                       clock,
   input  logic                                       reset,

   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic [1:0]                                 req_kind,
   input  logic signed [npss_pkg::COORD_BITS-1:0]     req_coord_x,
   input  logic signed [npss_pkg::COORD_BITS-1:0]     req_coord_y,
   input  logic signed [npss_pkg::COORD_BITS-1:0]     req_coord_z,
   input  logic [npss_pkg::TAG_W-1:0]                 req_pair_tag,

   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic                                       rsp_found,
   output logic [npss_pkg::INDEX_OUT_W-1:0]           rsp_match_index,
   output logic signed [npss_pkg::COORD_BITS-1:0]     rsp_match_x,
   output logic signed [npss_pkg::COORD_BITS-1:0]     rsp_match_y,
   output logic signed [npss_pkg::COORD_BITS-1:0]     rsp_match_z,
   output logic [npss_pkg::DIST_W-1:0]                rsp_distance_squared,
   output logic [npss_pkg::TAG_W-1:0]                 rsp_tag_out,
   output logic                                       rsp_store_full
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   npss_pkg::state_type           state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [IDX_W-1:0]              scan_idx_ff, scan_idx_in;
   logic [npss_pkg::DRAIN_W-1:0]  drain_cnt_ff, drain_cnt_in;
   npss_pkg::point_type           query_ff, query_in;
   logic [npss_pkg::TAG_W-1:0]    tag_ff, tag_in;
   logic                          found_ff, found_in;
   logic                          full_ff, full_in;

   // read stage of the point memory
   logic                          rd_valid_ff;
   logic [IDX_W-1:0]              rd_idx_ff;
   npss_pkg::point_type           rd_point_ff;
   npss_pkg::point_type           store_mem [MAX_POINTS];

   // output register
   logic                          rsp_valid_ff;
   logic                          rsp_found_ff;
   logic [npss_pkg::INDEX_OUT_W-1:0] rsp_index_ff;
   npss_pkg::point_type           rsp_point_ff;
   logic [npss_pkg::DIST_W-1:0]   rsp_dist_ff;
   logic [npss_pkg::TAG_W-1:0]    rsp_tag_ff;
   logic                          rsp_full_ff;

   npss_pkg::point_type           req_point;
   npss_pkg::kind_type            kind;
   logic                          req_fire;
   logic                          rsp_free;
   logic                          store_is_full;
   logic                          last_issue;
   logic                          issue;
   logic                          store_we;
   logic                          rsp_load;

   npss_pkg::cand_type            cand;
   logic [IDX_W-1:0]              cand_idx;
   logic [IDX_W-1:0]              best_idx;
   npss_pkg::point_type           best_point;
   logic [npss_pkg::DIST_W-1:0]   best_dist;
   logic [31:0]                   best_idx_wide;

   assign req_point.x   = req_coord_x;
   assign req_point.y   = req_coord_y;
   assign req_point.z   = req_coord_z;
   assign kind          = npss_pkg::kind_type'(req_kind);
   assign req_fire      = req_valid && !req_stall;
   assign rsp_free      = !rsp_valid_ff || !rsp_stall;
   assign store_is_full = (count_ff == CNT_W'(MAX_POINTS));
   assign last_issue    = (CNT_W'(scan_idx_ff) == (count_ff - CNT_W'(1)));
   assign best_idx_wide = 32'(best_idx);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         npss_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (kind)
                  npss_pkg::KIND_QUERY: begin
                     state_in = (count_ff == '0) ? npss_pkg::ST_DONE : npss_pkg::ST_SCAN;
                  end
                  npss_pkg::KIND_LOAD: begin
                     if (store_is_full) begin
                        state_in = npss_pkg::ST_DONE;
                     end
                  end
                  default: state_in = npss_pkg::ST_IDLE;
               endcase
            end
         end
         npss_pkg::ST_SCAN: begin
            if (last_issue) begin
               state_in = npss_pkg::ST_DRAIN;
            end
         end
         npss_pkg::ST_DRAIN: begin
            if (drain_cnt_ff == npss_pkg::DRAIN_W'(npss_pkg::DRAIN_CYCLES - 1)) begin
               state_in = npss_pkg::ST_DONE;
            end
         end
         npss_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = npss_pkg::ST_IDLE;
            end
         end
         default: state_in = npss_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_stall    = (state_ff != npss_pkg::ST_IDLE);
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      drain_cnt_in = drain_cnt_ff;
      query_in     = query_ff;
      tag_in       = tag_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      issue        = 1'b0;
      store_we     = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         npss_pkg::ST_IDLE: begin
            scan_idx_in  = '0;
            drain_cnt_in = '0;
            if (req_fire) begin
               query_in = req_point;
               tag_in   = req_pair_tag;
               found_in = 1'b0;
               full_in  = 1'b0;
               case (kind)
                  npss_pkg::KIND_LOAD: begin
                     if (store_is_full) begin
                        full_in = 1'b1;
                     end else begin
                        store_we = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  npss_pkg::KIND_QUERY: begin
                     found_in = (count_ff != '0);
                  end
                  npss_pkg::KIND_CLEAR: begin
                     count_in = '0;
                  end
                  default: count_in = count_ff;
               endcase
            end
         end
         npss_pkg::ST_SCAN: begin
            issue       = 1'b1;
            scan_idx_in = scan_idx_ff + IDX_W'(1);
         end
         npss_pkg::ST_DRAIN: begin
            drain_cnt_in = drain_cnt_ff + npss_pkg::DRAIN_W'(1);
         end
         npss_pkg::ST_DONE: begin
            rsp_load = rsp_free;
         end
         default: issue = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= npss_pkg::ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rd_valid_ff <= issue;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      drain_cnt_ff <= drain_cnt_in;
      query_ff     <= query_in;
      tag_ff       <= tag_in;
      found_ff     <= found_in;
      full_ff      <= full_in;
      rd_idx_ff    <= scan_idx_ff;
   end

   // point memory: one write port for loads, one registered read port for the scan
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[count_ff[IDX_W-1:0]] <= req_point;
      end
      rd_point_ff <= store_mem[scan_idx_ff];
   end

   // result register; an empty query or a dropped load reports zeros
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_full_ff  <= full_ff;
         rsp_tag_ff   <= tag_ff;
         if (found_ff) begin
            rsp_index_ff <= best_idx_wide[npss_pkg::INDEX_OUT_W-1:0];
            rsp_point_ff <= best_point;
            rsp_dist_ff  <= best_dist;
         end else begin
            rsp_index_ff <= '0;
            rsp_point_ff <= '0;
            rsp_dist_ff  <= '0;
         end
      end
   end

   npss_dist_unit #(
      .IDX_W(IDX_W)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid_ff),
      .in_idx   (rd_idx_ff),
      .in_point (rd_point_ff),
      .query    (query_ff),
      .cand     (cand),
      .cand_idx (cand_idx)
   );

   npss_best_track #(
      .IDX_W(IDX_W)
   ) u_best (
      .clock      (clock),
      .cand       (cand),
      .cand_idx   (cand_idx),
      .best_idx   (best_idx),
      .best_point (best_point),
      .best_dist  (best_dist)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_match_index      = rsp_index_ff;
   assign rsp_match_x          = rsp_point_ff.x;
   assign rsp_match_y          = rsp_point_ff.y;
   assign rsp_match_z          = rsp_point_ff.z;
   assign rsp_distance_squared = rsp_dist_ff;
   assign rsp_tag_out          = rsp_tag_ff;
   assign rsp_store_full       = rsp_full_ff;

endmodule

/* src/npss_checker.sv */
module npss_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic [1:0]                             req_kind,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic                                   rsp_found,
   input logic [npss_pkg::INDEX_OUT_W-1:0]       rsp_match_index,
   input logic signed [npss_pkg::COORD_BITS-1:0] rsp_match_x,
   input logic signed [npss_pkg::COORD_BITS-1:0] rsp_match_y,
   input logic signed [npss_pkg::COORD_BITS-1:0] rsp_match_z,
   input logic [npss_pkg::DIST_W-1:0]            rsp_distance_squared,
   input logic [npss_pkg::TAG_W-1:0]             rsp_tag_out,
   input logic                                   rsp_store_full
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tag_out)
         && $stable(rsp_distance_squared) && $stable(rsp_match_index))
      else $error("stalled result changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_found_xor_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_store_full))
      else $error("result flags both found and store full");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_distance_squared == '0 && rsp_match_index == '0
         && rsp_match_x == '0 && rsp_match_y == '0 && rsp_match_z == '0)
      else $error("no-match result carries nonzero match fields");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == npss_pkg::KIND_QUERY |=> req_stall)
      else $error("query transfer not followed by busy");

endmodule

bind nearest_point_search_3d_unit npss_checker u_npss_checker (.*);
